// ----- hdl/hstc_pkg.sv -----
package hstc_pkg;

  // Field widths
  localparam int unsigned CoordW   = 10;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned CountW   = 21;
  localparam int unsigned SumW     = 30;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 21;

  // Frame bounds; compare width covers the largest supported frame (1024)
  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 1024;
  localparam int unsigned CoordCmpW  = 13;

  // Divider steps: one quotient bit per step
  localparam int unsigned DivSteps   = CoordW;
  localparam int unsigned DivStepW   = $clog2(DivSteps);

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegHueLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHueHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSatLow  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSatHigh = 3'd3;
  localparam logic [CfgIdxW-1:0] RegValLow  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegValHigh = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMinArea = 3'd6;

  // Register reset values
  localparam logic [ChanW-1:0]  HueLowRst  = 8'd100;
  localparam logic [ChanW-1:0]  HueHighRst = 8'd120;
  localparam logic [ChanW-1:0]  SatLowRst  = 8'd150;
  localparam logic [ChanW-1:0]  SatHighRst = 8'd255;
  localparam logic [ChanW-1:0]  ValLowRst  = 8'd0;
  localparam logic [ChanW-1:0]  ValHighRst = 8'd255;
  localparam logic [CountW-1:0] MinAreaRst = 21'd1000;

  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [ChanW-1:0]  hue;
    logic [ChanW-1:0]  sat;
    logic [ChanW-1:0]  val;
    logic              frame_end;
  } in_t;

  typedef struct packed {
    logic              in_range;
    logic              frame_done;
    logic              object_found;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic              draw_segment;
    logic [CoordW-1:0] from_x;
    logic [CoordW-1:0] from_y;
  } out_t;

  typedef struct packed {
    logic [ChanW-1:0]  hue_low;
    logic [ChanW-1:0]  hue_high;
    logic [ChanW-1:0]  sat_low;
    logic [ChanW-1:0]  sat_high;
    logic [ChanW-1:0]  val_low;
    logic [ChanW-1:0]  val_high;
    logic [CountW-1:0] min_area;
  } cfg_t;

  // Divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hdl/hsv_threshold_centroid_tracker.sv -----
// Plain pixel word: result valid the cycle after acceptance; one word per cycle unless
// the output stalls. Frame-end word: the sequencer walks check, div x, div y and done
// when the area test passes (two 10-step divisions on one shared compare-subtract unit),
// check and done when it fails; input stalls meanwhile, until the result is issued.
// Reset (async, active low): thresholds to defaults, count/sums/previous centroid
// cleared, no result pending.
module hsv_threshold_centroid_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hstc_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hstc_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [hstc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hstc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import hstc_pkg::*;

  // Sequencer: idle takes pixels; frame end: check, div x/y if area passes, done.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIVX  = 5'b00100,
    S_DIVY  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  cfg_t cfg_q;

  // Moment accumulators
  logic [CountW-1:0] count_q, count_d;
  logic [SumW-1:0]   sum_x_q, sum_x_d;
  logic [SumW-1:0]   sum_y_q, sum_y_d;

  // Previous centroid
  logic              prev_valid_q, prev_valid_d;
  logic [CoordW-1:0] prev_x_q, prev_x_d;
  logic [CoordW-1:0] prev_y_q, prev_y_d;

  // Frame-end word in flight
  logic              pass_q, pass_d;
  logic              found_q, found_d;
  logic [CoordW-1:0] cx_q, cx_d;
  logic [CoordW-1:0] cy_q, cy_d;

  // Output register
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic out_free;

  logic in_acc;
  logic pass;
  logic add_ok;
  logic [SumW:0] sx_next, sy_next;

  logic              div_start;
  logic [SumW-1:0]   div_dividend;
  div_stat_t         div_stat;
  logic [CoordW-1:0] div_quo;

  hstc_mask u_mask (
    .pix_i  (in_data_i),
    .cfg_i  (cfg_q),
    .pass_o (pass)
  );

  hstc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (count_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // Output slot can take a word if empty or draining this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Saturation guard: skip the pixel if any accumulator would wrap
  always_comb begin
    sx_next = {1'b0, sum_x_q} + (SumW+1)'(in_data_i.pixel_x);
    sy_next = {1'b0, sum_y_q} + (SumW+1)'(in_data_i.pixel_y);
    add_ok  = pass && (count_q != {CountW{1'b1}}) && !sx_next[SumW] && !sy_next[SumW];
  end

  // Divider start: x once the area test passes, y as soon as x is out
  assign div_start    = ((state_q == S_CHECK) && (count_q > cfg_q.min_area)) ||
                        ((state_q == S_DIVX) && div_stat.done);
  assign div_dividend = (state_q == S_CHECK) ? sum_x_q : sum_y_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    sum_x_d      = sum_x_q;
    sum_y_d      = sum_y_q;
    prev_valid_d = prev_valid_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    pass_d       = pass_q;
    found_d      = found_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (add_ok) begin
            count_d = count_q + 1'b1;
            sum_x_d = sx_next[SumW-1:0];
            sum_y_d = sy_next[SumW-1:0];
          end
          if (in_data_i.frame_end) begin
            pass_d  = pass;
            state_d = S_CHECK;
          end else begin
            // plain pixel: mask bit only
            out_d          = '0;
            out_d.in_range = pass;
            out_valid_d    = 1'b1;
          end
        end
      end
      S_CHECK: begin
        found_d = count_q > cfg_q.min_area;
        cx_d    = '0;
        cy_d    = '0;
        state_d = (count_q > cfg_q.min_area) ? S_DIVX : S_DONE;
      end
      S_DIVX: begin
        if (div_stat.done) begin
          cx_d    = div_quo;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_stat.done) begin
          cy_d    = div_quo;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d              = '0;
          out_d.in_range     = pass_q;
          out_d.frame_done   = 1'b1;
          out_d.object_found = found_q;
          out_d.center_x     = cx_q;
          out_d.center_y     = cy_q;
          if (found_q && prev_valid_q) begin
            out_d.draw_segment = 1'b1;
            out_d.from_x       = prev_x_q;
            out_d.from_y       = prev_y_q;
          end
          if (found_q) begin
            prev_valid_d = 1'b1;
            prev_x_d     = cx_q;
            prev_y_d     = cy_q;
          end
          out_valid_d = 1'b1;
          count_d     = '0;
          sum_x_d     = '0;
          sum_y_d     = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low  <= HueLowRst;
      cfg_q.hue_high <= HueHighRst;
      cfg_q.sat_low  <= SatLowRst;
      cfg_q.sat_high <= SatHighRst;
      cfg_q.val_low  <= ValLowRst;
      cfg_q.val_high <= ValHighRst;
      cfg_q.min_area <= MinAreaRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHueLow:  cfg_q.hue_low  <= cfg_data_i[ChanW-1:0];
        RegHueHigh: cfg_q.hue_high <= cfg_data_i[ChanW-1:0];
        RegSatLow:  cfg_q.sat_low  <= cfg_data_i[ChanW-1:0];
        RegSatHigh: cfg_q.sat_high <= cfg_data_i[ChanW-1:0];
        RegValLow:  cfg_q.val_low  <= cfg_data_i[ChanW-1:0];
        RegValHigh: cfg_q.val_high <= cfg_data_i[ChanW-1:0];
        RegMinArea: cfg_q.min_area <= cfg_data_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      prev_valid_q <= 1'b0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      sum_x_q      <= sum_x_d;
      sum_y_q      <= sum_y_d;
      prev_valid_q <= prev_valid_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q  <= pass_d;
    found_q <= found_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/hstc_mask.sv -----
module hstc_mask (
  input  hstc_pkg::in_t  pix_i,
  input  hstc_pkg::cfg_t cfg_i,
  output logic           pass_o
);
  import hstc_pkg::*;

  logic in_frame;
  logic hue_ok, sat_ok, val_ok;

  always_comb begin
    in_frame = ({{(CoordCmpW-CoordW){1'b0}}, pix_i.pixel_x} < CoordCmpW'(MaxWidth)) &&
               ({{(CoordCmpW-CoordW){1'b0}}, pix_i.pixel_y} < CoordCmpW'(MaxHeight));
    hue_ok = (pix_i.hue >= cfg_i.hue_low) && (pix_i.hue <= cfg_i.hue_high);
    sat_ok = (pix_i.sat >= cfg_i.sat_low) && (pix_i.sat <= cfg_i.sat_high);
    val_ok = (pix_i.val >= cfg_i.val_low) && (pix_i.val <= cfg_i.val_high);
    pass_o = in_frame && hue_ok && sat_ok && val_ok;
  end

endmodule

// ----- hdl/hstc_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Quotient is known to fit CoordW bits: each sum is at most 1023 x count.
module hstc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hstc_pkg::SumW-1:0]   dividend_i,
  input  logic [hstc_pkg::CountW-1:0] divisor_i,
  output hstc_pkg::div_stat_t         stat_o,
  output logic [hstc_pkg::CoordW-1:0] quotient_o
);
  import hstc_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivStepW-1:0] step_q, step_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic [CountW-1:0]   dsr_q, dsr_d;
  logic [CoordW-1:0]   dvd_q, dvd_d;
  logic [CoordW-1:0]   quo_q, quo_d;

  logic [CountW:0] trial;
  logic [CountW:0] diff;
  logic            ge;

  // shared compare-subtract
  always_comb begin
    trial = {rem_q, dvd_q[CoordW-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = trial >= {1'b0, dsr_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = {{(CountW-(SumW-CoordW)){1'b0}}, dividend_i[SumW-1:CoordW]};
      dvd_d  = dividend_i[CoordW-1:0];
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[CountW-1:0] : trial[CountW-1:0];
      quo_d = {quo_q[CoordW-2:0], ge};
      dvd_d = {dvd_q[CoordW-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (step_q == DivStepW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule
